// ===== hdl/slpg_pkg.sv =====
`default_nettype none
package slpg_pkg;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_SET   = 2'd1,
		REQ_FLASH = 2'd2
	} req_t;

	typedef enum logic [3:0] {
		ST_OFF       = 4'd0,
		ST_BOOT      = 4'd1,
		ST_SEARCH    = 4'd2,
		ST_CONNECTED = 4'd3,
		ST_AP        = 4'd4,
		ST_CLIENT    = 4'd5,
		ST_RECORDING = 4'd6,
		ST_GPS       = 4'd7,
		ST_ERROR     = 4'd8
	} status_t;

	localparam int unsigned TIME_W  = 11;
	localparam int unsigned STAT_W  = 4;
	localparam int unsigned REQ_W   = 2;
	localparam int unsigned FLASH_W = 32;
	localparam int unsigned CHAN_W  = 8;

	localparam logic [TIME_W-1:0] SINCE_LIMIT = 11'd2000;
	localparam logic [TIME_W-1:0] SINCE_LAST  = 11'd1999;
	localparam logic [TIME_W-1:0] T_HALF_SEC  = 11'd1000;
	localparam logic [TIME_W-1:0] T_SEARCH    = 11'd500;
	localparam logic [TIME_W-1:0] T_CONN_ON   = 11'd200;
	localparam logic [TIME_W-1:0] T_CONN_OFF  = 11'd1800;
	localparam logic [TIME_W-1:0] T_GPS_ON    = 11'd150;
	localparam logic [TIME_W-1:0] T_GPS_OFF   = 11'd850;
	localparam logic [TIME_W-1:0] T_ERROR     = 11'd100;
	localparam logic [TIME_W-1:0] T_AP_P1_END = 11'd100;
	localparam logic [TIME_W-1:0] T_AP_P2_BEG = 11'd200;
	localparam logic [TIME_W-1:0] T_AP_P2_END = 11'd300;

	// x/25 == (x * 1311) >> 15 for x up to 1000
	localparam int unsigned         FADE_PROD_W = 22;
	localparam int unsigned         FADE_SHIFT  = 15;
	localparam logic [TIME_W-1:0]   FADE_RECIP  = 11'd1311;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

	localparam rgb_t C_BLACK  = '{r: 8'd0,  g: 8'd0,  b: 8'd0};
	localparam rgb_t C_BLUE   = '{r: 8'd0,  g: 8'd0,  b: 8'd40};
	localparam rgb_t C_YELLOW = '{r: 8'd40, g: 8'd30, b: 8'd0};
	localparam rgb_t C_GREEN  = '{r: 8'd0,  g: 8'd40, b: 8'd0};
	localparam rgb_t C_ORANGE = '{r: 8'd40, g: 8'd15, b: 8'd0};
	localparam rgb_t C_DIMGRN = '{r: 8'd0,  g: 8'd10, b: 8'd0};
	localparam rgb_t C_CYAN   = '{r: 8'd0,  g: 8'd30, b: 8'd40};
	localparam rgb_t C_RED    = '{r: 8'd40, g: 8'd0,  b: 8'd0};

	typedef struct packed {
		rgb_t rgb;
		logic restart;
		logic phase;
	} pat_res_t;

endpackage
`default_nettype wire

// ===== hdl/slpg_pattern.sv =====
`default_nettype none
module slpg_pattern (
	input  wire logic [slpg_pkg::STAT_W-1:0] active,
	input  wire logic [slpg_pkg::TIME_W-1:0] sat,
	input  wire logic [slpg_pkg::TIME_W-1:0] modv,
	input  wire logic                        phase,
	output slpg_pkg::pat_res_t               res
);

	logic [slpg_pkg::TIME_W-1:0]      cyc;
	logic [slpg_pkg::TIME_W-1:0]      fade_x;
	logic [slpg_pkg::FADE_PROD_W-1:0] fade_prod;
	logic [slpg_pkg::CHAN_W-1:0]      fade_lvl;

	always_comb begin
		cyc = (modv >= slpg_pkg::T_HALF_SEC) ? modv - slpg_pkg::T_HALF_SEC : modv;
		fade_x = (modv < slpg_pkg::T_HALF_SEC) ? modv : slpg_pkg::SINCE_LIMIT - modv;
		fade_prod = slpg_pkg::FADE_PROD_W'(fade_x) * slpg_pkg::FADE_PROD_W'(slpg_pkg::FADE_RECIP);
		fade_lvl = slpg_pkg::CHAN_W'(fade_prod >> slpg_pkg::FADE_SHIFT);
	end

	always_comb begin
		res.rgb     = slpg_pkg::C_BLACK;
		res.restart = 1'b0;
		res.phase   = phase;
		case (active)
			slpg_pkg::ST_BOOT: begin
				res.rgb = slpg_pkg::C_BLUE;
			end
			slpg_pkg::ST_SEARCH: begin
				if (sat >= slpg_pkg::T_SEARCH) begin
					res.phase   = ~phase;
					res.restart = 1'b1;
				end
				res.rgb = res.phase ? slpg_pkg::C_YELLOW : slpg_pkg::C_BLACK;
			end
			slpg_pkg::ST_CONNECTED: begin
				if (!phase && sat >= slpg_pkg::T_CONN_ON) begin
					res.phase   = 1'b1;
					res.restart = 1'b1;
				end else if (phase && sat >= slpg_pkg::T_CONN_OFF) begin
					res.phase   = 1'b0;
					res.restart = 1'b1;
				end
				res.rgb = res.phase ? slpg_pkg::C_BLACK : slpg_pkg::C_GREEN;
			end
			slpg_pkg::ST_AP: begin
				if (cyc < slpg_pkg::T_AP_P1_END ||
				    (cyc >= slpg_pkg::T_AP_P2_BEG && cyc < slpg_pkg::T_AP_P2_END)) begin
					res.rgb = slpg_pkg::C_ORANGE;
				end
			end
			slpg_pkg::ST_CLIENT: begin
				res.rgb = slpg_pkg::C_DIMGRN;
			end
			slpg_pkg::ST_RECORDING: begin
				res.rgb.r = fade_lvl;
			end
			slpg_pkg::ST_GPS: begin
				if (!phase && sat >= slpg_pkg::T_GPS_ON) begin
					res.phase   = 1'b1;
					res.restart = 1'b1;
				end else if (phase && sat >= slpg_pkg::T_GPS_OFF) begin
					res.phase   = 1'b0;
					res.restart = 1'b1;
				end
				res.rgb = res.phase ? slpg_pkg::C_BLACK : slpg_pkg::C_CYAN;
			end
			slpg_pkg::ST_ERROR: begin
				if (sat >= slpg_pkg::T_ERROR) begin
					res.phase   = ~phase;
					res.restart = 1'b1;
				end
				res.rgb = res.phase ? slpg_pkg::C_RED : slpg_pkg::C_BLACK;
			end
			default: begin
				res.rgb = slpg_pkg::C_BLACK;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/status_led_pattern_generator.sv =====
// Status LED pattern generator.
// Input channel (in_valid/in_ready): one request per transfer. req_type
// selects a 1 ms tick, a steady status set, or a temporary flash timed by
// flash_ms in milliseconds. Only ticks give a result; set and flash requests
// update state silently, and request type 3 is dropped.
// Output channel (out_valid/out_ready): one red/green/blue triple per tick.
// Timing: a tick accepted into the input stage is registered there, and
// its color is loaded into the output register when the tick advances,
// which it does only while the output register is empty or its color is
// being accepted; out_valid is driven by the output register.
// Throughput: one request per cycle unless a tick waits on a stalled output;
// the input stage and the output register each hold one item and the state update is combinational logic.
// When the receiver stalls, the output register holds its color; a tick in
// the input stage waits behind it, and in_ready falls only when both are
// full. Set and flash requests pass the input stage even during a stall.
// Reset clears the status, override, elapsed counts and blink phase, and
// empties both stages.
`default_nettype none
module status_led_pattern_generator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [slpg_pkg::REQ_W-1:0]    req_type,
	input  wire logic [slpg_pkg::STAT_W-1:0]   status_code,
	input  wire logic [slpg_pkg::FLASH_W-1:0]  flash_ms,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [slpg_pkg::CHAN_W-1:0]        red,
	output logic [slpg_pkg::CHAN_W-1:0]        green,
	output logic [slpg_pkg::CHAN_W-1:0]        blue
);

	logic                          valid_s1;
	logic [slpg_pkg::REQ_W-1:0]    req_s1;
	logic [slpg_pkg::STAT_W-1:0]   code_s1;
	logic [slpg_pkg::FLASH_W-1:0]  dur_s1;

	logic [slpg_pkg::STAT_W-1:0]   steady_q;
	logic [slpg_pkg::STAT_W-1:0]   ovr_status_q;
	logic [slpg_pkg::FLASH_W-1:0]  ovr_left_q;
	logic [slpg_pkg::TIME_W-1:0]   sat_q;
	logic [slpg_pkg::TIME_W-1:0]   mod_q;
	logic                          phase_q;

	logic                          out_valid_q;
	slpg_pkg::rgb_t                out_rgb_q;

	logic                          s1_tick;
	logic                          adv;
	logic [slpg_pkg::FLASH_W-1:0]  left_dec;
	logic [slpg_pkg::STAT_W-1:0]   active;
	logic [slpg_pkg::TIME_W-1:0]   sat_inc;
	logic [slpg_pkg::TIME_W-1:0]   mod_inc;
	slpg_pkg::pat_res_t            pat;

	assign s1_tick  = (req_s1 == slpg_pkg::REQ_TICK);
	assign adv      = valid_s1 && (!s1_tick || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_comb begin
		left_dec = ovr_left_q - 1'b1;
		active   = steady_q;
		if (ovr_left_q != '0 && left_dec != '0) begin
			active = ovr_status_q;
		end
		sat_inc = (sat_q < slpg_pkg::SINCE_LIMIT) ? sat_q + 1'b1 : sat_q;
		mod_inc = (mod_q == slpg_pkg::SINCE_LAST) ? '0 : mod_q + 1'b1;
	end

	slpg_pattern u_pattern (
		.active (active),
		.sat    (sat_inc),
		.modv   (mod_inc),
		.phase  (phase_q),
		.res    (pat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_type;
			code_s1 <= status_code;
			dur_s1  <= flash_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steady_q     <= '0;
			ovr_status_q <= '0;
			ovr_left_q   <= '0;
			sat_q        <= '0;
			mod_q        <= '0;
			phase_q      <= 1'b0;
		end else if (adv) begin
			case (req_s1)
				slpg_pkg::REQ_TICK: begin
					if (ovr_left_q != '0) begin
						ovr_left_q <= left_dec;
					end
					sat_q   <= pat.restart ? '0 : sat_inc;
					mod_q   <= pat.restart ? '0 : mod_inc;
					phase_q <= pat.phase;
				end
				slpg_pkg::REQ_SET: begin
					steady_q <= code_s1;
					phase_q  <= 1'b0;
					sat_q    <= '0;
					mod_q    <= '0;
				end
				slpg_pkg::REQ_FLASH: begin
					ovr_status_q <= code_s1;
					ovr_left_q   <= dur_s1;
					phase_q      <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && s1_tick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_tick) begin
			out_rgb_q <= pat.rgb;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = out_rgb_q.r;
	assign green     = out_rgb_q.g;
	assign blue      = out_rgb_q.b;

endmodule
`default_nettype wire

// ===== hdl/slpg_checker.sv =====
`default_nettype none
module slpg_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic [slpg_pkg::REQ_W-1:0]    req_type,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [slpg_pkg::CHAN_W-1:0]   red,
	input wire logic [slpg_pkg::CHAN_W-1:0]   green,
	input wire logic [slpg_pkg::CHAN_W-1:0]   blue
);

	localparam logic [slpg_pkg::CHAN_W-1:0] MAX_LVL = 8'd40;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
		else $error("result changed while stalled");

	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
			$past(in_valid && in_ready && req_type == slpg_pkg::REQ_TICK, 2))
		else $error("result without a tick transfer two cycles earlier");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> red <= MAX_LVL && green <= MAX_LVL && blue <= MAX_LVL)
		else $error("channel level out of range");

	a_blue_colors: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blue != '0 |-> blue == MAX_LVL && red == '0)
		else $error("blue channel in an unknown color");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.red       (red),
	.green     (green),
	.blue      (blue)
);
`default_nettype wire
